>>> design/ccm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_pkg: shared types, constants and AES helper functions
// Holds opcodes, status codes, the S-box, and round/key-schedule helpers.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int unsigned CcmM = 8;
  localparam int unsigned CcmL = 2;

  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpData   = 2'd1;
  localparam logic [1:0] OpFinish = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTagFail  = 2'd1;
  localparam logic [1:0] StLenFail  = 2'd2;

  localparam logic [2:0] CfgKey0 = 3'd0;
  localparam logic [2:0] CfgKey1 = 3'd1;
  localparam logic [2:0] CfgKey2 = 3'd2;
  localparam logic [2:0] CfgKey3 = 3'd3;
  localparam logic [2:0] CfgKeySize = 3'd4;

  localparam logic [7:0] FlagsB0 = 8'(((CcmM - 2) / 2) * 8 + (CcmL - 1));
  localparam logic [7:0] FlagsA  = 8'(CcmL - 1);

  // Kinds of work handed from front to back.
  typedef enum logic [1:0] {
    JobStart  = 2'd0,
    JobData   = 2'd1,
    JobFinish = 2'd2,
    JobEmpty  = 2'd3
  } job_kind_e;

  typedef struct packed {
    job_kind_e    kind;
    logic         direction;
    logic [39:0]  nonce_hi;
    logic [63:0]  nonce_lo;
    logic [15:0]  msg_len;
    logic [127:0] block;
    logic [4:0]   nbytes;
    logic [63:0]  tag_in;
  } job_t;

  typedef struct packed {
    logic [127:0] data;
    logic [4:0]   nbytes;
    logic [63:0]  tag;
    logic [1:0]   status;
    logic         last;
  } result_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One AES round on a 128-bit state, byte 0 in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = s[127 - 8 * i -: 8];
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        t[4 * c + row] = sbox(sb[4 * ((c + row) % 4) + row]);
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
    return r ^ rk;
  endfunction

endpackage

>>> design/ccm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_if: valid/ready channel interfaces
// Input, result and configuration channels of the CCM engine.
// ----------------------------------------------------------------------------
interface ccm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        direction;
  logic [39:0] nonce_hi;
  logic [63:0] nonce_lo;
  logic [15:0] msg_len;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [4:0]  block_bytes;
  logic [63:0] tag_in;
  modport source (output valid, op, direction, nonce_hi, nonce_lo, msg_len, block_hi,
                  block_lo, block_bytes, tag_in, input ready);
  modport sink (input valid, op, direction, nonce_hi, nonce_lo, msg_len, block_hi,
                block_lo, block_bytes, tag_in, output ready);
endinterface

interface ccm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic [4:0]  out_bytes;
  logic [63:0] tag_out;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, out_hi, out_lo, out_bytes, tag_out, status, last,
                  input ready);
  modport sink (input valid, out_hi, out_lo, out_bytes, tag_out, status, last,
                output ready);
endinterface

interface ccm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/aes_ccm_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ccm_engine_unit: AES-CCM engine, M = 8, L = 2, 13-byte nonce
// Front end queues decoded transactions; back end runs two AES cores.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  in_if   | in  | op, direction, nonce, msg_len, block, block_bytes, tag_in
//  out_if  | out | out_hi/lo, out_bytes, tag_out, status, last
//  cfg_if  | in  | register index and 64-bit write data (key words, key size)
//
// A start runs both cores in parallel, a data block two AES passes back to back
// (CTR then MAC), a finish no AES pass; a pass runs nr = 10/12/14 rounds by key
// size, on the round loop of each AES core.
// Reset clears control and message state; key resets to zero, 256-bit size.
// The job queue holds two transactions; the one-entry result register lets the
// MAC pass run while a data result waits, and a new job is taken only once that
// register is empty or being read.
module aes_ccm_engine_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  ccm_in_if.sink   in_if,
  ccm_out_if.source out_if,
  ccm_cfg_if.sink  cfg_if
);
  logic [63:0]   key_q [4];
  logic [1:0]    key_size_q;
  logic          job_valid, job_ready, back_busy;
  ccm_pkg::job_t job;

  // Key writes are always taken; the user must write keys only while idle, the block does not enforce it.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      key_size_q <= 2'd2;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ccm_pkg::CfgKey0:    key_q[0] <= cfg_if.data;
        ccm_pkg::CfgKey1:    key_q[1] <= cfg_if.data;
        ccm_pkg::CfgKey2:    key_q[2] <= cfg_if.data;
        ccm_pkg::CfgKey3:    key_q[3] <= cfg_if.data;
        ccm_pkg::CfgKeySize: key_size_q <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  ccm_front u_front (
    .clk_i, .rst_ni, .in_if,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  ccm_back u_back (
    .clk_i, .rst_ni,
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_size_i(key_size_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .busy_o(back_busy), .out_if
  );

  // Finish results always carry zero data bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.last |-> out_if.out_bytes == 5'd0)
    else $error("finish result with data bytes");

  // Data results never report a nonzero status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.last |-> out_if.status == ccm_pkg::StOk)
    else $error("status on data result");

  // Back end only takes a job while the front end offers one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready |-> job_valid)
    else $error("job taken from empty queue");

  // Valid result implies the back end reports busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> back_busy)
    else $error("result without busy");
endmodule

>>> design/ccm_aes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_aes_core: iterative AES encryption core
// One round per cycle; round keys expanded on the fly, at most one four-word group per round.
// ----------------------------------------------------------------------------
module ccm_aes_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] block_i,
  input  logic [255:0] key_i,
  input  logic [1:0]   key_size_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [127:0] block_o
);
  // Key schedule keeps the last nk words in a 256-bit window (w[i-nk..i-1]).
  logic [127:0] state_q, state_d;
  logic [255:0] win_q, win_d;
  logic [3:0]   round_q, round_d;
  logic [3:0]   nr;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   widx_q, widx_d;   // word index modulo nk of next word
  logic         busy_q, done_q;
  logic [3:0]   nk;
  logic [127:0] rk;
  logic [255:0] w;
  logic [31:0]  tmp, prev, neww;
  logic [7:0]   rc;
  logic [3:0]   wi;

  function automatic logic [31:0] sub_shift(input logic [31:0] p);
    logic [31:0] s;
    s = ccm_pkg::sub_word(p);
    return {s[23:0], s[31:24]};
  endfunction

  function automatic logic [31:0] oldest(input logic [255:0] v, input logic [3:0] n);
    case (n)
      4'd4:    return v[127:96];
      4'd6:    return v[191:160];
      default: return v[255:224];
    endcase
  endfunction

  always_comb begin
    case (key_size_i)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
  end

  // Generate the next four schedule words from the window; window holds nk words
  // right-aligned in the low 32*nk bits (newest lowest).
  always_comb begin
    w  = win_q;
    rc = rcon_q;
    wi = widx_q;
    rk = '0;
    for (int k = 0; k < 4; k++) begin
      prev = w[31:0];
      tmp  = prev;
      if (wi == 4'd0) begin
        tmp = sub_shift(prev) ^ {rc, 24'h0};
        rc  = ccm_pkg::xt(rc);
      end else if (nk == 4'd8 && wi == 4'd4) begin
        tmp = ccm_pkg::sub_word(prev);
      end
      neww = tmp ^ oldest(w, nk);
      w    = {w[223:0], neww};
      rk   = {rk[95:0], neww};
      wi   = (wi + 4'd1 == nk) ? 4'd0 : wi + 4'd1;
    end
    win_d  = w;
    rcon_d = rc;
    widx_d = wi;
  end

  // First round keys are the raw key; consume those before generating.
  logic [255:0] key_win;
  always_comb begin
    case (nk)
      4'd4:    key_win = {128'h0, key_i[255:128]};
      4'd6:    key_win = {64'h0, key_i[255:64]};
      default: key_win = key_i;
    endcase
  end

  // Round key for round r: for 256-bit keys rounds 0/1 come from the key directly,
  // for others the schedule runs ahead; keep it simple by a key-word FIFO.
  logic [383:0] kq_q, kq_d;     // pending schedule words, oldest at top
  logic [3:0]   kcnt_q, kcnt_d; // words pending
  logic         gen;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    kq_d    = kq_q;
    kcnt_d  = kcnt_q;
    gen     = 1'b0;
    if (start_i && !busy_q) begin
      // Queue only the raw key words past round key 0; keep the rest of the queue clear.
      state_d = block_i ^ key_i[255:128];
      case (nk)
        4'd4:    kq_d = '0;
        4'd6:    kq_d = {key_i[127:64], 320'h0};
        default: kq_d = {key_i[127:0], 256'h0};
      endcase
      kcnt_d  = nk - 4'd4;
      round_d = 4'd1;
    end else if (busy_q) begin
      // Need four words in the queue; if short, take four more from the generator.
      if (kcnt_q < 4'd4) begin
        gen = 1'b1;
        kq_d = kq_q | ({rk, 256'h0} >> (32 * kcnt_q));
        kcnt_d = kcnt_q + 4'd4;
      end
      state_d = ccm_pkg::aes_round(state_q, kq_d[383:256], round_q == nr);
      kq_d    = {kq_d[255:0], 128'h0};
      kcnt_d  = kcnt_d - 4'd4;
      round_d = round_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (round_q == nr);
      if (start_i && !busy_q) busy_q <= 1'b1;
      else if (busy_q && round_q == nr) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    round_q <= round_d;
    kq_q    <= kq_d;
    kcnt_q  <= kcnt_d;
    if (start_i && !busy_q) begin
      win_q  <= key_win;
      rcon_q <= 8'h01;
      widx_q <= 4'd0;
    end else if (gen) begin
      win_q  <= win_d;
      rcon_q <= rcon_d;
      widx_q <= widx_d;
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign block_o = state_q;
endmodule

>>> design/ccm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_front: input classifier and job queue
// Decode transactions into jobs (dropping bad ops and ops outside a message); hold up to two.
// ----------------------------------------------------------------------------
module ccm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ccm_in_if.sink        in_if,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output ccm_pkg::job_t job_o
);
  localparam int unsigned Depth = 2;

  ccm_pkg::job_t job_mem [Depth];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          msg_q;       // tracks open message for drop decisions
  logic          push, pop, drop;
  ccm_pkg::job_t job;
  logic [4:0]    nb;

  always_comb begin
    nb = (in_if.block_bytes > 5'd16) ? 5'd16 : in_if.block_bytes;
    job.direction = in_if.direction;
    job.nonce_hi  = in_if.nonce_hi;
    job.nonce_lo  = in_if.nonce_lo;
    job.msg_len   = in_if.msg_len;
    job.block     = {in_if.block_hi, in_if.block_lo};
    job.nbytes    = nb;
    job.tag_in    = in_if.tag_in;
    drop          = 1'b0;
    case (in_if.op)
      ccm_pkg::OpStart:  job.kind = ccm_pkg::JobStart;
      ccm_pkg::OpData:   job.kind = (nb == 5'd0) ? ccm_pkg::JobEmpty : ccm_pkg::JobData;
      ccm_pkg::OpFinish: job.kind = ccm_pkg::JobFinish;
      default: begin
        job.kind = ccm_pkg::JobEmpty;
        drop     = 1'b1;
      end
    endcase
    if (in_if.op != ccm_pkg::OpStart && !msg_q) drop = 1'b1;
  end

  assign in_if.ready = (cnt_q != 2'(Depth));
  assign push        = in_if.valid && in_if.ready && !drop;
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      msg_q    <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (in_if.valid && in_if.ready && !drop) begin
        if (in_if.op == ccm_pkg::OpStart) msg_q <= 1'b1;
        else if (in_if.op == ccm_pkg::OpFinish) msg_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) job_mem[wr_ptr_q] <= job;
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = job_mem[rd_ptr_q];
endmodule

>>> design/ccm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_back: CCM job execution
// Run CTR and CBC-MAC encryptions on two AES cores and keep message state.
// ----------------------------------------------------------------------------
module ccm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [255:0]    key_i,
  input  logic [1:0]      key_size_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  ccm_pkg::job_t   job_i,
  output logic            busy_o,
  ccm_out_if.source       out_if
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SAes1 = 2'd1;   // start: B0 and A0 in parallel
  localparam logic [1:0] SCtr  = 2'd2;   // data: CTR keystream
  localparam logic [1:0] SMac  = 2'd3;   // data: MAC fold

  logic [1:0]   st_q, st_d;
  logic [127:0] mac_q;
  logic [39:0]  nhi_q;
  logic [63:0]  nlo_q;
  logic [15:0]  ctr_q;
  logic [63:0]  mask_q;
  logic [16:0]  exp_q;
  logic         dec_q;
  ccm_pkg::job_t job_q;

  logic         a_start, b_start, a_busy, b_busy, a_done, b_done;
  logic [127:0] a_in, b_in, a_out, b_out;
  logic         res_full_q;
  ccm_pkg::result_t res_q;
  logic         take, res_load;
  ccm_pkg::result_t res_d;
  logic [127:0] bmask, ctext, xblk;

  ccm_aes_core u_aes_a (
    .clk_i, .rst_ni, .start_i(a_start), .block_i(a_in), .key_i, .key_size_i,
    .busy_o(a_busy), .done_o(a_done), .block_o(a_out)
  );
  ccm_aes_core u_aes_b (
    .clk_i, .rst_ni, .start_i(b_start), .block_i(b_in), .key_i, .key_size_i,
    .busy_o(b_busy), .done_o(b_done), .block_o(b_out)
  );

  // Result slot frees as soon as the sink takes it.
  assign out_if.valid = res_full_q;
  assign take = job_valid_i && (st_q == SIdle) && (!res_full_q || out_if.ready);
  assign job_ready_o = take;
  assign busy_o = (st_q != SIdle) || res_full_q || a_busy || b_busy;

  always_comb begin
    for (int i = 0; i < 16; i++)
      bmask[127 - 8 * i -: 8] = (5'(i) < job_q.nbytes) ? 8'hff : 8'h00;
    ctext = (job_q.block ^ a_out) & bmask;
    xblk  = mac_q ^ ((dec_q ? ctext : job_q.block) & bmask);
  end

  always_comb begin
    st_d     = st_q;
    a_start  = 1'b0;
    b_start  = 1'b0;
    a_in     = {ccm_pkg::FlagsB0, job_i.nonce_hi, job_i.nonce_lo, job_i.msg_len};
    b_in     = {ccm_pkg::FlagsA, job_i.nonce_hi, job_i.nonce_lo, 16'h0};
    res_load = 1'b0;
    res_d    = '0;
    case (st_q)
      SIdle: begin
        if (take) begin
          case (job_i.kind)
            ccm_pkg::JobStart: begin
              a_start = 1'b1;
              b_start = 1'b1;
              st_d    = SAes1;
            end
            ccm_pkg::JobData: begin
              a_start = 1'b1;
              a_in    = {ccm_pkg::FlagsA, nhi_q, nlo_q, ctr_q};
              st_d    = SCtr;
            end
            ccm_pkg::JobFinish: begin
              res_load    = 1'b1;
              res_d.last  = 1'b1;
              if (exp_q != 17'd0) res_d.status = ccm_pkg::StLenFail;
              else if (dec_q && (mac_q[127:64] ^ mask_q) != job_i.tag_in)
                res_d.status = ccm_pkg::StTagFail;
              else res_d.status = ccm_pkg::StOk;
              res_d.tag = dec_q ? 64'h0 : (mac_q[127:64] ^ mask_q);
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      SAes1: if (a_done) st_d = SIdle;
      SCtr: begin
        if (a_done) begin
          b_start = 1'b1;
          b_in    = xblk;
          res_load     = 1'b1;
          res_d.data   = ctext;
          res_d.nbytes = job_q.nbytes;
          st_d = SMac;
        end
      end
      SMac: if (b_done) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= SIdle;
      res_full_q <= 1'b0;
      mac_q <= '0; nhi_q <= '0; nlo_q <= '0; ctr_q <= '0;
      mask_q <= '0; exp_q <= '0; dec_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_load) res_full_q <= 1'b1;
      else if (out_if.ready) res_full_q <= 1'b0;
      if (take && job_i.kind == ccm_pkg::JobStart) begin
        nhi_q <= job_i.nonce_hi;
        nlo_q <= job_i.nonce_lo;
        ctr_q <= 16'd1;
        exp_q <= {1'b0, job_i.msg_len};
        dec_q <= job_i.direction;
      end
      if (st_q == SAes1 && a_done) begin
        mac_q  <= a_out;
        mask_q <= b_out[127:64];
      end
      if (st_q == SCtr && a_done) begin
        ctr_q <= ctr_q + 16'd1;
        if (!exp_q[16]) begin
          if ({12'h0, job_q.nbytes} > exp_q) exp_q <= 17'h10000;
          else exp_q <= exp_q - {12'h0, job_q.nbytes};
        end
      end
      if (st_q == SMac && b_done) mac_q <= b_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    if (res_load) res_q <= res_d;
  end

  assign out_if.out_hi    = res_q.data[127:64];
  assign out_if.out_lo    = res_q.data[63:0];
  assign out_if.out_bytes = res_q.nbytes;
  assign out_if.tag_out   = res_q.tag;
  assign out_if.status    = res_q.status;
  assign out_if.last      = res_q.last;
endmodule
